/* rtl/rqba_pkg.sv */
// Shared types and constants for the ring queue with bulk access.
// Used by every module of the block except rqba_ram; depends on nothing.
package rqba_pkg;

   // Field widths of the item, result and ring size channels
   localparam int MODE_W  = 3;
   localparam int LEN_W   = 9;
   localparam int ELEM_W  = 8;
   localparam int CNT_W   = 8;
   localparam int QSIZE_W = 9;

   // Smallest usable ring size
   localparam int QSIZE_MIN = 2;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SCAN    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LEN_W-1:0]  length;
      logic [ELEM_W-1:0] data_in;
   } rqba_req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] data_out;
      logic              ok;
      logic              last;
      logic [CNT_W-1:0]  fill_count;
      logic [CNT_W-1:0]  free_space;
   } rqba_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic take;       // item accepted this cycle
      logic rd_start;   // first slot fetch of a read or scan, from the read pointer
      logic rd_next;    // further slot fetch, from the scan position
      logic rd_remove;  // fetch removes the element (read, not scan)
      logic rd_last;    // fetch yields the final result of the item
   } rqba_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rd_legal;   // read or scan length is within limits and fill
   } rqba_status_type;

endpackage

/* rtl/rqba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module rqba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/rqba_ctrl.sv */
// Controller of the ring queue: accepts items and sequences the slot fetches
// of multi-element reads and scans. Uses rqba_pkg.
module rqba_ctrl #(
   parameter int MAX_BURST = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rqba_pkg::rqba_req_type    req_item,
   input  rqba_pkg::rqba_status_type status,
   output rqba_pkg::rqba_cmd_type    cmd,
   output logic                      busy
);
   import rqba_pkg::*;

   localparam int CW = $clog2(MAX_BURST + 1);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_RUN  = 1'b1;

   logic [0:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          remove_ff, remove_in;
   logic          is_fetch;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      remove_in = remove_ff;
      cmd       = '0;
      is_fetch  = (req_item.mode == MODE_READ) || (req_item.mode == MODE_SCAN);
      case (state_ff)
         ST_IDLE: begin
            cmd.take = start;
            if (start && is_fetch && status.rd_legal) begin
               cmd.rd_start  = 1'b1;
               cmd.rd_remove = (req_item.mode == MODE_READ);
               cmd.rd_last   = (req_item.length == LEN_W'(1));
               if (!cmd.rd_last) begin
                  // remaining fetches after the first one
                  state_in  = ST_RUN;
                  cnt_in    = CW'(req_item.length - LEN_W'(1));
                  remove_in = cmd.rd_remove;
               end
            end
         end
         ST_RUN: begin
            cmd.rd_next   = 1'b1;
            cmd.rd_remove = remove_ff;
            cmd.rd_last   = (cnt_ff == CW'(1));
            cnt_in        = cnt_ff - CW'(1);
            if (cmd.rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         remove_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         remove_ff <= remove_in;
      end
   end

   assign busy = (state_ff == ST_RUN);

`ifndef ASSERT_OFF
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff != '0))
      else $error("fetch sequence running with zero count");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == CW'(1)) |=> (state_ff == ST_IDLE))
      else $error("fetch sequence did not end after final fetch");
`endif

endmodule

/* rtl/rqba_dp.sv */
// Datapath of the ring queue: pointers, ring size, burst state, slot memory
// and result registers. Uses rqba_pkg and rqba_ram.
module rqba_dp #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rqba_pkg::rqba_req_type               req_item,
   input  rqba_pkg::rqba_cmd_type               cmd,
   input  logic                                 csr_we,
   input  logic [rqba_pkg::QSIZE_W-1:0]         csr_wdata,
   output rqba_pkg::rqba_status_type            status,
   output logic                                 rsp_strobe,
   output rqba_pkg::rqba_rsp_type               rsp_item
);
   import rqba_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW   = (AW < QSIZE_W) ? AW : QSIZE_W;
   localparam int QW   = PW + 1;
   localparam int XW   = (QW > LEN_W) ? QW : LEN_W;
   localparam int QRST = (DEPTH > 256) ? 256 : DEPTH;
   localparam int QMAX = (DEPTH > 511) ? 511 : DEPTH;
   localparam logic [QSIZE_W:0] QMAX_V = (QSIZE_W + 1)'(QMAX);

   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [QW-1:0]     qsize_ff, qsize_in;
   logic [LEN_W-1:0]  brem_ff, brem_in;
   logic              bacc_ff, bacc_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_dsel_ff, rsp_dsel_in;

   logic [QW-1:0]     fill;
   logic [QW-1:0]     room;
   logic [QW-1:0]     free;
   logic [XW-1:0]     len_x;
   logic [XW:0]       dsum;
   logic              acc;
   logic              store;
   logic              fetch;
   logic [PW-1:0]     rd_src;
   logic [PW-1:0]     rd_nxt;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_raddr;
   logic [ELEM_W-1:0] ram_rdata;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p,
                                             input logic [QW-1:0] q);
      logic [QW-1:0] n;
      n = QW'(p) + QW'(1);
      return (n == q) ? '0 : PW'(n);
   endfunction

   // Occupancy from the pointers; both stay below the ring size
   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         fill = QW'(wr_ptr_ff) - QW'(rd_ptr_ff);
      end else begin
         fill = QW'(wr_ptr_ff) + qsize_ff - QW'(rd_ptr_ff);
      end
      room = qsize_ff - fill;
      free = room - QW'(1);
   end

   assign len_x = XW'(req_item.length);
   assign status.rd_legal = (req_item.length != '0)
                         && (len_x <= XW'(MAX_BURST))
                         && (len_x <= XW'(fill));

   assign fetch  = cmd.rd_start || cmd.rd_next;
   assign rd_src = cmd.rd_start ? rd_ptr_ff : pos_ff;
   assign rd_nxt = ptr_inc(rd_src, qsize_ff);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      pos_in      = pos_ff;
      qsize_in    = qsize_ff;
      brem_in     = brem_ff;
      bacc_in     = bacc_ff;
      rsp_vld_in  = 1'b0;
      rsp_ok_in   = rsp_ok_ff;
      rsp_last_in = rsp_last_ff;
      rsp_dsel_in = rsp_dsel_ff;
      acc         = 1'b0;
      store       = 1'b0;
      ram_we      = 1'b0;
      dsum        = (XW + 1)'(rd_ptr_ff) + (XW + 1)'(req_item.length);

      if (cmd.take) begin
         rsp_vld_in  = 1'b1;
         rsp_last_in = 1'b1;
         rsp_dsel_in = 1'b0;
         rsp_ok_in   = 1'b1;
         case (req_item.mode)
            MODE_WRITE: begin
               if (brem_ff == '0) begin
                  // first element decides the whole burst
                  acc     = (len_x < XW'(room));
                  bacc_in = acc;
                  if (req_item.length != '0) begin
                     brem_in = req_item.length - LEN_W'(1);
                     store   = acc && (free != '0);
                  end
               end else begin
                  acc     = bacc_ff;
                  brem_in = brem_ff - LEN_W'(1);
                  store   = acc && (free != '0);
               end
               if (req_item.length == '0 && brem_ff == '0) begin
                  rsp_ok_in = acc;
               end else begin
                  rsp_ok_in = store;
               end
               if (store) begin
                  ram_we    = 1'b1;
                  wr_ptr_in = ptr_inc(wr_ptr_ff, qsize_ff);
               end
            end
            MODE_READ, MODE_SCAN: begin
               // legal requests are answered by the fetch path
               if (!status.rd_legal) begin
                  rsp_ok_in = 1'b0;
               end else begin
                  rsp_vld_in = 1'b0;
               end
            end
            MODE_DISCARD: begin
               if (len_x > XW'(fill)) begin
                  wr_ptr_in = '0;
                  rd_ptr_in = '0;
               end else begin
                  if (dsum >= (XW + 1)'(qsize_ff)) begin
                     dsum = dsum - (XW + 1)'(qsize_ff);
                  end
                  rd_ptr_in = PW'(dsum);
               end
            end
            MODE_CLEAR: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
      end

      if (fetch) begin
         pos_in      = rd_nxt;
         rsp_vld_in  = 1'b1;
         rsp_ok_in   = 1'b1;
         rsp_last_in = cmd.rd_last;
         rsp_dsel_in = 1'b1;
         if (cmd.rd_remove) begin
            rd_ptr_in = rd_nxt;
         end
      end

      if (csr_we) begin
         if (csr_wdata < QSIZE_W'(QSIZE_MIN)) begin
            qsize_in = QW'(QSIZE_MIN);
         end else if ({1'b0, csr_wdata} > QMAX_V) begin
            qsize_in = QW'(QMAX);
         end else begin
            qsize_in = QW'(csr_wdata);
         end
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         brem_in   = '0;
         bacc_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         qsize_ff   <= QW'(QRST);
         brem_ff    <= '0;
         bacc_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         qsize_ff   <= qsize_in;
         brem_ff    <= brem_in;
         bacc_ff    <= bacc_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
      rsp_dsel_ff <= rsp_dsel_in;
   end

   assign ram_waddr = AW'(wr_ptr_ff);
   assign ram_raddr = AW'(rd_src);

   rqba_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_item.data_in),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_strobe          = rsp_vld_ff;
   assign rsp_item.data_out   = rsp_dsel_ff ? ram_rdata : '0;
   assign rsp_item.ok         = rsp_ok_ff;
   assign rsp_item.last       = rsp_last_ff;
   assign rsp_item.fill_count = CNT_W'(fill);
   assign rsp_item.free_space = CNT_W'(free);

`ifndef ASSERT_OFF
   a_wr_ptr_range: assert property (@(posedge clock) disable iff (reset)
      QW'(wr_ptr_ff) < qsize_ff)
      else $error("write pointer outside ring");

   a_rd_ptr_range: assert property (@(posedge clock) disable iff (reset)
      QW'(rd_ptr_ff) < qsize_ff)
      else $error("read pointer outside ring");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && fetch))
      else $error("slot write and fetch in the same cycle");
`endif

endmodule

/* rtl/ring_queue_bulk_access.sv */
// Ring queue with bulk access: circular element queue with burst writes,
// multi-element reads and scans, discard and clear.
// Built from rqba_ctrl and rqba_dp; uses rqba_pkg.
//
// Items enter on req_item and are taken at a clock edge where start is high
// and busy is low. Results leave on rsp_item, each valid for the single cycle
// in which rsp_strobe is high; the receiver cannot stall them.
// Write, discard, clear, refused and unknown requests give one result in the
// cycle after acceptance, and a new item can be taken every cycle.
// A read or scan of n elements gives n results back to back, the first in the
// cycle after acceptance; busy stays high during the later fetches, since
// every element is one fetch through the single read port of the slot memory.
// The next item can be taken in the cycle that carries the final result.
// csr_we with csr_wdata sets the ring size (clamped to 2..DEPTH, at most 511)
// and empties the queue; write it only while no results are pending.
// Synchronous reset empties the queue, ends any open write burst and sets the
// ring size to 256 (or DEPTH if smaller). Slot contents are not cleared.
module ring_queue_bulk_access #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  rqba_pkg::rqba_req_type       req_item,
   output logic                         rsp_strobe,
   output rqba_pkg::rqba_rsp_type       rsp_item,
   input  logic                         csr_we,
   input  logic [rqba_pkg::QSIZE_W-1:0] csr_wdata
);
   import rqba_pkg::*;

   rqba_cmd_type    cmd;
   rqba_status_type status;

   rqba_ctrl #(
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   rqba_dp #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
